>>> hdl/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// shared types, constants and the per-byte predictor for scanline unfiltering
// ----------------------------------------------------------------------------
package pngu_pkg;

    localparam int C_MAX_WIDTH   = 1024;
    localparam int C_ROW_WIDTH_W = 11;
    localparam int C_HEIGHT_W    = 16;
    localparam int C_CFG_INDEX_W = 2;
    localparam int C_CFG_DATA_W  = 16;
    localparam int C_PIXEL_W     = 32;
    localparam int C_CHANNELS    = 4;

    // configuration register indexes
    localparam logic [C_CFG_INDEX_W-1:0] C_CFG_ROW_WIDTH    = 2'd0;
    localparam logic [C_CFG_INDEX_W-1:0] C_CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [C_CFG_INDEX_W-1:0] C_CFG_HAS_ALPHA    = 2'd2;

    // filter codes
    localparam logic [7:0] C_FILT_NONE  = 8'd0;
    localparam logic [7:0] C_FILT_SUB   = 8'd1;
    localparam logic [7:0] C_FILT_UP    = 8'd2;
    localparam logic [7:0] C_FILT_AVG   = 8'd3;
    localparam logic [7:0] C_FILT_PAETH = 8'd4;

    localparam logic [7:0] C_BYTE_MASK = 8'hff;

    typedef logic [7:0]           t_byte;
    typedef logic [C_PIXEL_W-1:0] t_pixel;

    typedef struct packed {
        logic [7:0] filter_type;
        logic       has_alpha;
    } t_recon_ctrl;

    // predictor of one channel; unknown codes act as none
    function automatic t_byte f_predict(input logic [7:0] kind, input t_byte a,
                                        input t_byte b, input t_byte c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [9:0] ab;
        logic [9:0] cc;
        t_byte      pred;
        pa = (b > c) ? {2'b00, 8'(b - c)} : {2'b00, 8'(c - b)};
        pb = (a > c) ? {2'b00, 8'(a - c)} : {2'b00, 8'(c - a)};
        ab = {2'b00, a} + {2'b00, b};
        cc = {1'b0, c, 1'b0};
        pc = (ab > cc) ? (ab - cc) : (cc - ab);
        case (kind)
            C_FILT_NONE:  pred = 8'h00;
            C_FILT_SUB:   pred = a;
            C_FILT_UP:    pred = b;
            C_FILT_AVG:   pred = ab[8:1];
            C_FILT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = a;
                end else if (pb <= pc) begin
                    pred = b;
                end else begin
                    pred = c;
                end
            end
            default:      pred = 8'h00;
        endcase
        return pred;
    endfunction

endpackage

>>> hdl/png_scanline_unfilter_top.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// png filter reconstruction (none, sub, up, average, paeth) for 8-bit rgb/rgba
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+-------------------------------
//  input    | in        | i_valid / o_stall      | filter type, filtered r g b a
//  output   | out       | o_valid / i_stall      | reconstructed r g b a, row/image end
//  config   | in        | i_cfg_valid / o_cfg_ready | register index, write data
//
//  one item per clock while the output is not stalled; a result passes the
//  compute stage, then the output register, before it is offered
//  the previous-row line buffer is a ram with a registered read, read when an item
//  is accepted and written back when the item leaves the compute stage
//  reset (synchronous, active low) clears counters, left/upper-left pixels, valid
//  flags and alpha, sets width and height to one; the line buffer is not cleared
//  a stall on the output holds the compute stage, which stalls the input
//  only when both the output register and the compute stage are full
//
module png_scanline_unfilter_top #(
    parameter int MAX_WIDTH = pngu_pkg::C_MAX_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input items
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [7:0]                              i_filter_type,
    input  logic [7:0]                              i_in_red,
    input  logic [7:0]                              i_in_green,
    input  logic [7:0]                              i_in_blue,
    input  logic [7:0]                              i_in_alpha,
    // result items
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [7:0]                              o_out_red,
    output logic [7:0]                              o_out_green,
    output logic [7:0]                              o_out_blue,
    output logic [7:0]                              o_out_alpha,
    output logic                                    o_end_of_row,
    output logic                                    o_end_of_image,
    // configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [pngu_pkg::C_CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [pngu_pkg::C_CFG_DATA_W-1:0]       i_cfg_data
);
    import pngu_pkg::*;

    // column counter width and a compare width that holds both width sources
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = ((CW > C_ROW_WIDTH_W) ? CW : C_ROW_WIDTH_W) + 1;

    // configuration registers
    logic [C_ROW_WIDTH_W-1:0] r_row_width;
    logic [C_HEIGHT_W-1:0]    r_image_height;
    logic                     r_has_alpha;

    // position counters
    logic [CW-1:0]            r_col;
    logic [C_HEIGHT_W-1:0]    r_row;
    logic [CW-1:0]            n_col;
    logic [C_HEIGHT_W-1:0]    n_row;

    // neighbor pixels
    t_pixel                   r_left;
    t_pixel                   r_upper_left;

    // compute stage
    logic                     r_s1_valid;
    logic [7:0]               r_s1_filter;
    t_pixel                   r_s1_pixel;
    logic [CW-1:0]            r_s1_col;
    logic                     r_s1_eor;
    logic                     r_s1_eoi;
    logic                     r_s1_row0;
    logic                     r_fwd;
    t_pixel                   r_fwd_data;

    // output register
    logic                     r_out_valid;
    t_pixel                   r_out_pixel;
    logic                     r_out_eor;
    logic                     r_out_eoi;

    logic                     w_accept;
    logic                     w_s1_move;
    logic [LW-1:0]            w_rw_ext;
    logic [LW-1:0]            w_eff_w;
    logic [C_HEIGHT_W-1:0]    w_eff_h;
    logic                     w_eor;
    logic                     w_eoi;
    t_pixel                   w_rdata;
    t_pixel                   w_above;
    t_pixel                   w_result;
    t_recon_ctrl              w_ctrl;

    // handshakes: compute stage moves when the output register is free or taken
    assign w_s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !w_s1_move;
    assign w_accept  = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // effective width: zero acts as one, clamp at the line buffer depth
    assign w_rw_ext = LW'(r_row_width);
    always_comb begin
        if (w_rw_ext == '0) begin
            w_eff_w = LW'(1);
        end else if (w_rw_ext > LW'(MAX_WIDTH)) begin
            w_eff_w = LW'(MAX_WIDTH);
        end else begin
            w_eff_w = w_rw_ext;
        end
    end
    assign w_eff_h = (r_image_height == '0) ? C_HEIGHT_W'(1) : r_image_height;

    // a count at or past the last index ends the row or image at once
    assign w_eor = LW'(r_col) >= (w_eff_w - LW'(1));
    assign w_eoi = w_eor && (r_row >= (w_eff_h - C_HEIGHT_W'(1)));

    always_comb begin
        if (w_eor) begin
            n_col = '0;
            n_row = w_eoi ? '0 : r_row + C_HEIGHT_W'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // line buffer of the previous scanline
    pngu_ram #(
        .WIDTH (C_PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_s1_move),
        .i_waddr (r_s1_col),
        .i_wdata (w_result),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_rdata)
    );

    // row 0 sees zeros above; a write to the entry being read is forwarded
    always_comb begin
        if (r_s1_row0) begin
            w_above = '0;
        end else if (r_fwd) begin
            w_above = r_fwd_data;
        end else begin
            w_above = w_rdata;
        end
    end

    assign w_ctrl.filter_type = r_s1_filter;
    assign w_ctrl.has_alpha   = r_has_alpha;

    pngu_recon u_recon (
        .i_ctrl       (w_ctrl),
        .i_pixel      (r_s1_pixel),
        .i_left       (r_left),
        .i_above      (w_above),
        .i_upper_left (r_upper_left),
        .o_result     (w_result)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= C_ROW_WIDTH_W'(1);
            r_image_height <= C_HEIGHT_W'(1);
            r_has_alpha    <= 1'b0;
            r_col          <= '0;
            r_row          <= '0;
            r_left         <= '0;
            r_upper_left   <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    C_CFG_ROW_WIDTH:    r_row_width    <= i_cfg_data[C_ROW_WIDTH_W-1:0];
                    C_CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[C_HEIGHT_W-1:0];
                    C_CFG_HAS_ALPHA:    r_has_alpha    <= i_cfg_data[0];
                    default:            ;
                endcase
            end
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            // left and upper-left follow the item leaving the compute stage
            if (w_s1_move) begin
                if (r_s1_eor) begin
                    r_left       <= '0;
                    r_upper_left <= '0;
                end else begin
                    r_left       <= w_result;
                    r_upper_left <= w_above;
                end
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_filter <= i_filter_type;
            r_s1_pixel  <= {i_in_alpha, i_in_blue, i_in_green, i_in_red};
            r_s1_col    <= r_col;
            r_s1_eor    <= w_eor;
            r_s1_eoi    <= w_eoi;
            r_s1_row0   <= (r_row == '0);
            r_fwd       <= w_s1_move && (r_s1_col == r_col);
        end
        if (w_s1_move) begin
            r_fwd_data  <= w_result;
            r_out_pixel <= w_result;
            r_out_eor   <= r_s1_eor;
            r_out_eoi   <= r_s1_eoi;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_red      = r_out_pixel[7:0];
    assign o_out_green    = r_out_pixel[15:8];
    assign o_out_blue     = r_out_pixel[23:16];
    assign o_out_alpha    = r_out_pixel[31:24];
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_image = r_out_eoi;

    // a held compute stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_move |=> r_s1_valid && $stable(r_s1_col))
        else $error("compute stage lost its item while held");

    // image end only ever comes with a row end
    a_eoi_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_end_of_image || o_end_of_row))
        else $error("end of image without end of row");

    // a row end returns the column to zero
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_eor |=> r_col == '0)
        else $error("column counter did not wrap at row end");

    // alpha stays zero when alpha is off
    a_alpha_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_has_alpha |-> o_out_alpha == 8'h00)
        else $error("alpha not zero with alpha disabled");

endmodule

>>> hdl/pngu_ram.sv
// ----------------------------------------------------------------------------
// pngu_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pngu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/pngu_recon.sv
// ----------------------------------------------------------------------------
// pngu_recon
// per-channel reconstruction of one pixel from left, above and upper-left
// ----------------------------------------------------------------------------
module pngu_recon (
    input  pngu_pkg::t_recon_ctrl i_ctrl,
    input  pngu_pkg::t_pixel      i_pixel,
    input  pngu_pkg::t_pixel      i_left,
    input  pngu_pkg::t_pixel      i_above,
    input  pngu_pkg::t_pixel      i_upper_left,
    output pngu_pkg::t_pixel      o_result
);
    import pngu_pkg::*;

    t_pixel w_raw;

    for (genvar ch = 0; ch < C_CHANNELS; ch++) begin : g_ch
        assign w_raw[ch*8 +: 8] = i_pixel[ch*8 +: 8]
            + f_predict(i_ctrl.filter_type, i_left[ch*8 +: 8],
                        i_above[ch*8 +: 8], i_upper_left[ch*8 +: 8]);
    end

    // alpha byte forced to zero without alpha
    assign o_result = {w_raw[31:24] & (i_ctrl.has_alpha ? C_BYTE_MASK : 8'h00),
                       w_raw[23:0]};

endmodule
